// ----- hw/rtl/lfbc_pkg.sv -----
// Shared types, codes and helper functions for the LIN frame builder and checker.
`default_nettype none

package lfbc_pkg;

  // Operation codes carried in the input tuser field
  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_SEND   = 2'd1;
  localparam logic [1:0] OP_RECV   = 2'd2;

  // Result kinds carried in the output tuser field
  localparam logic [1:0] KIND_LINE    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // Verdict codes
  localparam logic [2:0] VER_OK       = 3'd0;
  localparam logic [2:0] VER_STATUS   = 3'd1;
  localparam logic [2:0] VER_PID      = 3'd2;
  localparam logic [2:0] VER_CHECKSUM = 3'd3;
  localparam logic [2:0] VER_LENGTH   = 3'd4;

  // Receive positions before the data bytes
  localparam logic [3:0] RX_POS_MARKER = 4'd0;
  localparam logic [3:0] RX_POS_SYNC   = 4'd1;
  localparam logic [3:0] RX_POS_PID    = 4'd2;
  localparam logic [3:0] RX_POS_DATA   = 4'd3;

  localparam logic [7:0] SYNC_BYTE = 8'h55;

  // Most results one transaction can produce on the transmit side
  localparam int unsigned JOB_SLOTS = 4;

  // One accepted input transaction
  typedef struct packed {
    logic [1:0] op;
    logic [5:0] frame_id;
    logic       enhanced;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [3:0] data_length;
  } in_item_t;

  // One result transaction without its last flag
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [2:0] verdict;
  } res_item_t;

  // Results of one input: explicit slots, or a payload release of len bytes
  typedef struct packed {
    logic                        release_pl;
    logic [3:0]                  count;
    logic [3:0]                  len;
    res_item_t [JOB_SLOTS-1:0]   slots;
  } job_t;

  function automatic res_item_t lfbc_item(input logic [1:0] kind,
                                          input logic [7:0] value,
                                          input logic [2:0] verdict);
    res_item_t r;
    r.kind    = kind;
    r.value   = value;
    r.verdict = verdict;
    return r;
  endfunction

  // Protected identifier: parity bits 6 and 7 over the six id bits
  function automatic logic [7:0] lfbc_make_pid(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // Eight-bit add with end-around carry
  function automatic logic [7:0] lfbc_add_carry(input logic [7:0] sum,
                                                input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, sum} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lin_frame_builder_checker_unit.sv -----
// LIN frame builder/checker: one byte transaction produces 0 to 9 results, one per cycle
// while out_tready is high; an input passes the input and emitter job registers first.
// Throughput: one input per cycle while out_tready is high and each input makes at most
// one result; more results hold the next input until the single port sends the last one.
// Reset: synchronous active-low rst_n clears tx/rx frame state and both stage valids;
// stored payload bytes are not cleared.
`default_nettype none

module lin_frame_builder_checker_unit
  import lfbc_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // frame_id[5:0], enhanced[6], data_byte[14:7],
                                       // data_length[18:15], zero fill
  input  wire logic [1:0]  in_tuser,   // op[1:0]
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // value[7:0], verdict[10:8], zero fill
  output logic [1:0]       out_tuser,  // kind[1:0]
  output logic             out_tlast   // last
);

  localparam int unsigned IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic          item_valid;
  in_item_t      item;
  logic          consume;
  logic          load_ok;
  logic          job_load;
  job_t          job;
  logic [IW-1:0] rd_idx;
  logic [7:0]    rd_data;

  lfbc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  lfbc_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .IW          (IW)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .load_ok    (load_ok),
    .consume    (consume),
    .job_load   (job_load),
    .job        (job),
    .rd_idx     (rd_idx),
    .rd_data    (rd_data)
  );

  lfbc_emitter #(
    .IW (IW)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_load   (job_load),
    .job        (job),
    .load_ok    (load_ok),
    .rd_idx     (rd_idx),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/lfbc_in_stage.sv -----
// Input register stage: captures one stream transaction and holds it until consumed.
`default_nettype none

module lfbc_in_stage
  import lfbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tlast,
  input  wire logic        consume,
  output logic             item_valid,
  output in_item_t         item
);

  logic     valid_r;
  in_item_t item_r;

  // Take a new transaction when empty or when the held one leaves
  assign in_tready  = !valid_r || consume;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // Hold payload fields; no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.op          <= in_tuser;
      item_r.frame_id    <= in_tdata[5:0];
      item_r.enhanced    <= in_tdata[6];
      item_r.data_byte   <= in_tdata[14:7];
      item_r.last_byte   <= in_tlast;
      item_r.data_length <= in_tdata[18:15];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lfbc_core.sv -----
// Frame state and per-transaction decode: builds the result job and updates tx/rx state.
`default_nettype none

module lfbc_core
  import lfbc_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 8,
  parameter int unsigned IW          = 3
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          item_valid,
  input  wire in_item_t      item,
  input  wire logic          load_ok,
  output logic               consume,
  output logic               job_load,
  output job_t               job,
  input  wire logic [IW-1:0] rd_idx,
  output logic [7:0]         rd_data
);

  localparam logic [3:0] MaxCnt = 4'(MAX_PAYLOAD);

  logic [3:0] tx_count_r, tx_count_nxt;
  logic [7:0] tx_sum_r, tx_sum_nxt;
  logic [7:0] tx_pid_r, tx_pid_nxt;
  logic [3:0] rx_position_r, rx_position_nxt;
  logic [3:0] rx_length_r, rx_length_nxt;
  logic [7:0] rx_expected_pid_r, rx_expected_pid_nxt;
  logic       rx_pid_ok_r, rx_pid_ok_nxt;
  logic [7:0] rx_sum_r, rx_sum_nxt;
  logic       rx_checksum_ok_r, rx_checksum_ok_nxt;
  logic       rx_enhanced_r, rx_enhanced_nxt;
  logic [7:0] rx_payload_r [MAX_PAYLOAD];

  logic       pl_wr;
  logic [IW-1:0] pl_idx;
  logic [7:0] pid_in;
  logic       tx_first;
  logic [7:0] tx_pid_sel;
  logic [7:0] tx_base;
  logic [7:0] tx_sum_new;
  logic [3:0] rx_end;

  assign pid_in     = lfbc_make_pid(item.frame_id);
  assign tx_first   = (tx_count_r == 4'd0);
  assign tx_pid_sel = tx_first ? pid_in : tx_pid_r;
  assign tx_base    = tx_first ? (item.enhanced ? tx_pid_sel : 8'd0) : tx_sum_r;
  assign tx_sum_new = lfbc_add_carry(tx_base, item.data_byte);
  assign rx_end     = RX_POS_DATA + rx_length_r;
  assign pl_idx     = IW'(rx_position_r - RX_POS_DATA);

  assign consume  = item_valid && load_ok;
  assign job_load = consume && (job.count != 4'd0);
  assign rd_data  = rx_payload_r[rd_idx];

  // Decode the held transaction into results and next state
  always_comb begin
    tx_count_nxt        = tx_count_r;
    tx_sum_nxt          = tx_sum_r;
    tx_pid_nxt          = tx_pid_r;
    rx_position_nxt     = rx_position_r;
    rx_length_nxt       = rx_length_r;
    rx_expected_pid_nxt = rx_expected_pid_r;
    rx_pid_ok_nxt       = rx_pid_ok_r;
    rx_sum_nxt          = rx_sum_r;
    rx_checksum_ok_nxt  = rx_checksum_ok_r;
    rx_enhanced_nxt     = rx_enhanced_r;
    pl_wr               = 1'b0;
    job                 = '0;
    case (item.op)
      OP_HEADER: begin
        job.slots[0]    = lfbc_item(KIND_LINE, SYNC_BYTE, VER_OK);
        job.slots[1]    = lfbc_item(KIND_LINE, pid_in, VER_OK);
        job.count       = 4'd2;
        rx_position_nxt = RX_POS_MARKER;
      end
      OP_SEND: begin
        if (tx_count_r >= MaxCnt) begin
          // Frame overflow: report and abandon the frame
          job.slots[0] = lfbc_item(KIND_VERDICT, 8'd0, VER_LENGTH);
          job.count    = 4'd1;
          tx_count_nxt = 4'd0;
        end else begin
          if (tx_first) begin
            job.slots[0] = lfbc_item(KIND_LINE, SYNC_BYTE, VER_OK);
            job.slots[1] = lfbc_item(KIND_LINE, tx_pid_sel, VER_OK);
            job.slots[2] = lfbc_item(KIND_LINE, item.data_byte, VER_OK);
            job.slots[3] = lfbc_item(KIND_LINE, ~tx_sum_new, VER_OK);
            job.count    = item.last_byte ? 4'd4 : 4'd3;
          end else begin
            job.slots[0] = lfbc_item(KIND_LINE, item.data_byte, VER_OK);
            job.slots[1] = lfbc_item(KIND_LINE, ~tx_sum_new, VER_OK);
            job.count    = item.last_byte ? 4'd2 : 4'd1;
          end
          tx_pid_nxt   = tx_pid_sel;
          tx_sum_nxt   = tx_sum_new;
          tx_count_nxt = item.last_byte ? 4'd0 : tx_count_r + 4'd1;
        end
      end
      OP_RECV: begin
        if (rx_position_r == RX_POS_MARKER) begin
          if (item.data_length == 4'd0 || item.data_length > MaxCnt) begin
            job.slots[0] = lfbc_item(KIND_VERDICT, 8'd0, VER_LENGTH);
            job.count    = 4'd1;
          end else begin
            rx_length_nxt       = item.data_length;
            rx_expected_pid_nxt = pid_in;
            rx_enhanced_nxt     = item.enhanced;
            rx_pid_ok_nxt       = 1'b0;
            rx_checksum_ok_nxt  = 1'b0;
            rx_sum_nxt          = 8'd0;
            rx_position_nxt     = RX_POS_SYNC;
          end
        end else if (rx_position_r == RX_POS_SYNC) begin
          rx_position_nxt = RX_POS_PID;
        end else if (rx_position_r == RX_POS_PID) begin
          rx_pid_ok_nxt   = (item.data_byte == rx_expected_pid_r);
          rx_sum_nxt      = rx_enhanced_r ? item.data_byte : 8'd0;
          rx_position_nxt = RX_POS_DATA;
        end else if (rx_position_r < rx_end) begin
          pl_wr           = 1'b1;
          rx_sum_nxt      = lfbc_add_carry(rx_sum_r, item.data_byte);
          rx_position_nxt = rx_position_r + 4'd1;
        end else if (rx_position_r == rx_end) begin
          rx_checksum_ok_nxt = ((~rx_sum_r) == item.data_byte);
          rx_position_nxt    = rx_position_r + 4'd1;
        end else begin
          // Status byte: status, then PID, then checksum
          if (item.data_byte != 8'd0) begin
            job.slots[0] = lfbc_item(KIND_VERDICT, 8'd0, VER_STATUS);
            job.count    = 4'd1;
          end else if (!rx_pid_ok_r) begin
            job.slots[0] = lfbc_item(KIND_VERDICT, 8'd0, VER_PID);
            job.count    = 4'd1;
          end else if (!rx_checksum_ok_r) begin
            job.slots[0] = lfbc_item(KIND_VERDICT, 8'd0, VER_CHECKSUM);
            job.count    = 4'd1;
          end else begin
            job.release_pl = 1'b1;
            job.len        = rx_length_r;
            job.count      = rx_length_r + 4'd1;
          end
          rx_position_nxt = RX_POS_MARKER;
        end
      end
      default: begin
      end
    endcase
  end

  // Advance frame state on each consumed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_count_r        <= 4'd0;
      tx_sum_r          <= 8'd0;
      tx_pid_r          <= 8'd0;
      rx_position_r     <= RX_POS_MARKER;
      rx_length_r       <= 4'd0;
      rx_expected_pid_r <= 8'd0;
      rx_pid_ok_r       <= 1'b0;
      rx_sum_r          <= 8'd0;
      rx_checksum_ok_r  <= 1'b0;
      rx_enhanced_r     <= 1'b0;
    end else if (consume) begin
      tx_count_r        <= tx_count_nxt;
      tx_sum_r          <= tx_sum_nxt;
      tx_pid_r          <= tx_pid_nxt;
      rx_position_r     <= rx_position_nxt;
      rx_length_r       <= rx_length_nxt;
      rx_expected_pid_r <= rx_expected_pid_nxt;
      rx_pid_ok_r       <= rx_pid_ok_nxt;
      rx_sum_r          <= rx_sum_nxt;
      rx_checksum_ok_r  <= rx_checksum_ok_nxt;
      rx_enhanced_r     <= rx_enhanced_nxt;
    end
  end

  // Store received payload bytes
  always_ff @(posedge clk) begin
    if (consume && pl_wr) begin
      rx_payload_r[pl_idx] <= item.data_byte;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lfbc_emitter.sv -----
// Result sequencer: holds one job and presents its results one transaction at a time.
`default_nettype none

module lfbc_emitter
  import lfbc_pkg::*;
#(
  parameter int unsigned IW = 3
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_load,
  input  wire job_t          job,
  output logic               load_ok,
  output logic [IW-1:0]      rd_idx,
  input  wire logic [7:0]    rd_data,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [15:0]        out_tdata,
  output logic [1:0]         out_tuser,
  output logic               out_tlast
);

  logic       valid_r;
  job_t       job_r;
  logic [3:0] idx_r;
  logic       is_last;
  res_item_t  cur;

  assign is_last = (idx_r == job_r.count - 4'd1);
  assign load_ok = !valid_r || (is_last && out_tready);
  assign rd_idx  = idx_r[IW-1:0];

  // Pick the current result: a slot, a stored payload byte or the ok verdict
  always_comb begin
    if (job_r.release_pl) begin
      if (idx_r < job_r.len) begin
        cur = lfbc_item(KIND_PAYLOAD, rd_data, VER_OK);
      end else begin
        cur = lfbc_item(KIND_VERDICT, 8'd0, VER_OK);
      end
    end else begin
      cur = job_r.slots[idx_r[1:0]];
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = cur.kind;
  assign out_tdata  = {5'd0, cur.verdict, cur.value};
  assign out_tlast  = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 4'd0;
    end else if (load_ok) begin
      valid_r <= job_load;
      idx_r   <= 4'd0;
    end else if (valid_r && out_tready) begin
      idx_r   <= idx_r + 4'd1;
    end
  end

  // Hold the job payload
  always_ff @(posedge clk) begin
    if (load_ok && job_load) begin
      job_r <= job;
    end
  end

endmodule

`default_nettype wire
